[rtl/mafhd_pkg.sv]
// ---------------------------------------------------------------------------
// mafhd_pkg
// Shared types, constants and lookup tables for the MPEG audio header decoder.
// ---------------------------------------------------------------------------
package mafhd_pkg;

    localparam int HDR_W       = 32;
    localparam int OUT_DATA_W  = 72;
    localparam int KBPS_W      = 9;
    localparam int COEF_W      = 8;
    localparam int PROD_W      = KBPS_W + COEF_W;
    localparam int NUM_W       = 20;
    localparam int QUO_W       = 12;
    localparam int LEN_W       = 11;

    localparam logic [10:0] SYNC_MARK      = 11'h7FF;
    localparam logic [1:0]  VER_RESERVED   = 2'd1;
    localparam logic [1:0]  VER_MPEG1      = 2'd3;
    localparam logic [1:0]  VER_MPEG2      = 2'd2;
    localparam logic [1:0]  VER_MPEG25     = 2'd0;
    localparam logic [1:0]  LAYER_CODE_BAD = 2'd0;
    localparam logic [1:0]  LAYER_I        = 2'd0;
    localparam logic [1:0]  LAYER_II       = 2'd1;
    localparam logic [1:0]  LAYER_III      = 2'd2;

    // Reciprocal constants for the three rate families
    localparam logic [16:0] RECIP_3     = 17'd43691;    // 2^17 / 3, rounded up
    localparam logic [20:0] RECIP_441   = 21'd1217394;  // 2^29 / 441, truncated
    localparam logic [8:0]  DIV_441     = 9'd441;
    localparam logic [3:0]  MUL_10      = 4'd10;
    localparam logic [9:0]  KBPS_SCALE  = 10'd1000;
    localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_SYNC      = 2'd1,
        FAULT_VER_LAYER = 2'd2,
        FAULT_RATE      = 2'd3
    } fault_t;

    // Sample rate family: base rate 44.1k, 48k or 32k, scaled down by version
    typedef enum logic [1:0] {
        FAM_44K = 2'd0,
        FAM_48K = 2'd1,
        FAM_32K = 2'd2
    } rate_fam_t;

    typedef struct packed {
        logic        ok;
        fault_t      fault;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic [15:0] rate;
        logic [18:0] bps;
        logic [10:0] spf;
        logic [1:0]  mode;
        logic        pad;
        logic        slot4;
    } info_t;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [KBPS_W-1:0] kbps;
        logic [1:0]        shift;
        rate_fam_t         fam;
    } scale_in_t;

    localparam logic [KBPS_W-1:0] KBPS_V1_L1 [16] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L2 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V1_L3 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L1 [16] = '{
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [KBPS_W-1:0] KBPS_V2_L23 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic lsf,
                                                      input logic [1:0] layer,
                                                      input logic [3:0] idx);
        logic [KBPS_W-1:0] res;
        res = '0;
        if (!lsf) begin
            case (layer)
                LAYER_I:   res = KBPS_V1_L1[idx];
                LAYER_II:  res = KBPS_V1_L2[idx];
                LAYER_III: res = KBPS_V1_L3[idx];
                default:   res = '0;
            endcase
        end else begin
            case (layer)
                LAYER_I:   res = KBPS_V2_L1[idx];
                LAYER_II:  res = KBPS_V2_L23[idx];
                LAYER_III: res = KBPS_V2_L23[idx];
                default:   res = '0;
            endcase
        end
        return res;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver,
                                                input logic [1:0] sr_idx);
        logic [15:0] res;
        res = '0;
        case ({ver, sr_idx})
            {VER_MPEG1, 2'd0}:  res = 16'd44100;
            {VER_MPEG1, 2'd1}:  res = 16'd48000;
            {VER_MPEG1, 2'd2}:  res = 16'd32000;
            {VER_MPEG2, 2'd0}:  res = 16'd22050;
            {VER_MPEG2, 2'd1}:  res = 16'd24000;
            {VER_MPEG2, 2'd2}:  res = 16'd16000;
            {VER_MPEG25, 2'd0}: res = 16'd11025;
            {VER_MPEG25, 2'd1}: res = 16'd12000;
            {VER_MPEG25, 2'd2}: res = 16'd8000;
            default:            res = '0;
        endcase
        return res;
    endfunction

endpackage

[rtl/mafhd_decode.sv]
// ---------------------------------------------------------------------------
// mafhd_decode
// Header field split, header checks and table lookups; one register stage.
// ---------------------------------------------------------------------------
module mafhd_decode
    import mafhd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [HDR_W-1:0] header_word,
    output logic             out_valid,
    input  logic             out_ready,
    output info_t            info,
    output scale_in_t        scale_in
);

    logic [10:0] sync;
    logic [1:0]  ver;
    logic [1:0]  lay_code;
    logic [3:0]  br_idx;
    logic [1:0]  sr_idx;
    logic [1:0]  layer;
    logic        lsf;
    logic [KBPS_W-1:0] kbps;
    logic [15:0] rate;
    logic [KBPS_W+9:0] bps_full;

    logic      valid_reg;
    info_t     info_reg;
    info_t     info_next;
    scale_in_t scale_reg;
    scale_in_t scale_next;

    assign sync     = header_word[31:21];
    assign ver      = header_word[20:19];
    assign lay_code = header_word[18:17];
    assign br_idx   = header_word[15:12];
    assign sr_idx   = header_word[11:10];
    assign layer    = 2'd3 - lay_code;
    assign lsf      = (ver != VER_MPEG1);
    assign kbps     = kbps_lookup(lsf, layer, br_idx);
    assign rate     = rate_lookup(ver, sr_idx);
    assign bps_full = kbps * KBPS_SCALE;

    always_comb
    begin
        info_next       = '0;
        info_next.ver   = ver;
        info_next.layer = layer;
        info_next.rate  = rate;
        info_next.bps   = bps_full[18:0];
        info_next.mode  = header_word[7:6];
        info_next.pad   = header_word[9];
        info_next.slot4 = (layer == LAYER_I);
        case (layer)
            LAYER_I:   info_next.spf = 11'd384;
            LAYER_II:  info_next.spf = 11'd1152;
            default:   info_next.spf = lsf ? 11'd576 : 11'd1152;
        endcase

        // Checks in priority order: sync, version/layer, rates
        if (sync != SYNC_MARK) begin
            info_next.fault = FAULT_SYNC;
        end else if (ver == VER_RESERVED || lay_code == LAYER_CODE_BAD) begin
            info_next.fault = FAULT_VER_LAYER;
        end else if (rate == '0 || kbps == '0) begin
            info_next.fault = FAULT_RATE;
        end else begin
            info_next.fault = FAULT_NONE;
        end
        info_next.ok = (info_next.fault == FAULT_NONE);

        scale_next      = '0;
        scale_next.kbps = kbps;
        case (layer)
            LAYER_I:  scale_next.coef = 8'd12;
            LAYER_II: scale_next.coef = 8'd144;
            default:  scale_next.coef = lsf ? 8'd72 : 8'd144;
        endcase
        // Lower versions halve or quarter the base rate
        case (ver)
            VER_MPEG2:  scale_next.shift = 2'd1;
            VER_MPEG25: scale_next.shift = 2'd2;
            default:    scale_next.shift = 2'd0;
        endcase
        case (sr_idx)
            2'd0:    scale_next.fam = FAM_44K;
            2'd1:    scale_next.fam = FAM_48K;
            default: scale_next.fam = FAM_32K;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            info_reg  <= info_next;
            scale_reg <= scale_next;
        end
    end

    assign out_valid = valid_reg;
    assign info      = info_reg;
    assign scale_in  = scale_reg;

endmodule

[rtl/mafhd_scale.sv]
// ---------------------------------------------------------------------------
// mafhd_scale
// Slot count = coef * bitrate / sample rate, truncated; four register stages.
// ---------------------------------------------------------------------------
module mafhd_scale
    import mafhd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  info_t            info_in,
    input  scale_in_t        scale_in,
    output logic             out_valid,
    input  logic             out_ready,
    output info_t            info_out,
    output logic [QUO_W-1:0] slots
);

    // Stage A: coef * kbps
    logic              va_reg;
    info_t             ia_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [1:0]        sha_reg;
    rate_fam_t         fa_reg;
    logic              ready_a;

    // Stage B: scale by version, times ten for the 44.1k family
    logic              vb_reg;
    info_t             ib_reg;
    logic [NUM_W-1:0]  numb_reg;
    logic [NUM_W-1:0]  num_next;
    rate_fam_t         fb_reg;
    logic              ready_b;
    logic [PROD_W+1:0] shifted;
    logic [PROD_W+5:0] times10;

    // Stage C: reciprocal multiply
    logic              vc_reg;
    info_t             ic_reg;
    logic [NUM_W-1:0]  numc_reg;
    logic [QUO_W-1:0]  qc_reg;
    logic [QUO_W-1:0]  q_next;
    rate_fam_t         fc_reg;
    logic              ready_c;
    logic [32:0]       p48;
    logic [40:0]       p44;

    // Stage D: one-step correction for the 441 divisor
    logic              vd_reg;
    info_t             id_reg;
    logic [QUO_W-1:0]  qd_reg;
    logic [QUO_W-1:0]  qfix_next;
    logic              ready_d;
    logic [QUO_W+8:0]  back;
    logic [QUO_W+8:0]  rem;

    assign ready_d  = !vd_reg || out_ready;
    assign ready_c  = !vc_reg || ready_d;
    assign ready_b  = !vb_reg || ready_c;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    assign shifted = {2'b00, prod_reg} << sha_reg;
    assign times10 = shifted * MUL_10;
    assign num_next = (fa_reg == FAM_44K) ? times10[NUM_W-1:0]
                                          : {{(NUM_W-PROD_W-2){1'b0}}, shifted};

    assign p48 = {1'b0, numb_reg[NUM_W-1:4]} * RECIP_3;
    assign p44 = numb_reg * RECIP_441;

    always_comb
    begin
        case (fb_reg)
            FAM_48K: q_next = p48[17+QUO_W-1:17];
            FAM_32K: q_next = numb_reg[5+QUO_W-1:5];
            default: q_next = p44[29+QUO_W-1:29];
        endcase
    end

    assign back = qc_reg * DIV_441;
    assign rem  = {{(QUO_W+9-NUM_W){1'b0}}, numc_reg} - back;

    always_comb
    begin
        qfix_next = qc_reg;
        if (fc_reg == FAM_44K && rem >= {{(QUO_W){1'b0}}, DIV_441}) begin
            qfix_next = qc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (ready_a) va_reg <= in_valid;
            if (ready_b) vb_reg <= va_reg;
            if (ready_c) vc_reg <= vb_reg;
            if (ready_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid) begin
            ia_reg   <= info_in;
            prod_reg <= scale_in.coef * scale_in.kbps;
            sha_reg  <= scale_in.shift;
            fa_reg   <= scale_in.fam;
        end
        if (ready_b && va_reg) begin
            ib_reg   <= ia_reg;
            numb_reg <= num_next;
            fb_reg   <= fa_reg;
        end
        if (ready_c && vb_reg) begin
            ic_reg   <= ib_reg;
            numc_reg <= numb_reg;
            qc_reg   <= q_next;
            fc_reg   <= fb_reg;
        end
        if (ready_d && vc_reg) begin
            id_reg <= ic_reg;
            qd_reg <= qfix_next;
        end
    end

    assign out_valid = vd_reg;
    assign info_out  = id_reg;
    assign slots     = qd_reg;

endmodule

[rtl/mpeg_audio_frame_header_decoder_unit.sv]
// ---------------------------------------------------------------------------
// mpeg_audio_frame_header_decoder_unit
// Pipelined MPEG-1/2/2.5 audio frame header decoder: checks and frame length.
// ---------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_*       in   32     header_word, first stream byte in bits 31..24
// m_*       out  72     decoded header fields, one transaction per header
//
// Six register stages: lookup, coef*kbps, rate scaling, reciprocal multiply,
// divisor correction, length/output register. One header enters every cycle
// while m_tready does not stall the pipeline.
// Reset clears only the valid bits. A stall on m_tready holds each full
// stage; empty stages ahead of it still fill, so bubbles are squeezed out.
// ---------------------------------------------------------------------------
module mpeg_audio_frame_header_decoder_unit
    import mafhd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [HDR_W-1:0]      s_tdata,   // [31:0] header_word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] header_ok, [2:1] fault_code,
                                             // [4:3] version_id, [6:5] layer_number,
                                             // [22:7] sample_rate_hz,
                                             // [41:23] bitrate_bps,
                                             // [52:42] samples_per_frame,
                                             // [54:53] channel_mode,
                                             // [65:55] frame_bytes, rest zero
);

    logic             dec_valid;
    logic             dec_ready;
    info_t            dec_info;
    scale_in_t        dec_scale;

    logic             scl_valid;
    logic             scl_ready;
    info_t            scl_info;
    logic [QUO_W-1:0] scl_slots;

    logic             out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [QUO_W:0]   slot_sum;
    logic [QUO_W+2:0] len_full;
    logic [LEN_W-1:0] len;

    // Split the header, run the checks and fetch the table values
    mafhd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .header_word (s_tdata),
        .out_valid   (dec_valid),
        .out_ready   (dec_ready),
        .info        (dec_info),
        .scale_in    (dec_scale)
    );

    // Slot count: coef * bitrate / rate, truncated
    mafhd_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .info_in   (dec_info),
        .scale_in  (dec_scale),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .info_out  (scl_info),
        .slots     (scl_slots)
    );

    // Add padding, convert slots to bytes (four per slot in Layer I),
    // saturate at the 11-bit field limit
    assign slot_sum = {1'b0, scl_slots} + {{QUO_W{1'b0}}, scl_info.pad};
    assign len_full = scl_info.slot4 ? {slot_sum, 2'b00} : {2'b00, slot_sum};
    assign len      = (len_full > {{(QUO_W+3-LEN_W){1'b0}}, LEN_MAX})
                      ? LEN_MAX : len_full[LEN_W-1:0];

    // Pack the result; a faulty header shows only its fault code
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[2:1]   = scl_info.fault;
        if (scl_info.ok) begin
            out_data_next[0]     = 1'b1;
            out_data_next[4:3]   = scl_info.ver;
            out_data_next[6:5]   = scl_info.layer;
            out_data_next[22:7]  = scl_info.rate;
            out_data_next[41:23] = scl_info.bps;
            out_data_next[52:42] = scl_info.spf;
            out_data_next[54:53] = scl_info.mode;
            out_data_next[65:55] = len;
        end
    end

    // Output register: advance when empty or when the sink takes the transaction
    assign scl_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (scl_ready) begin
            out_valid_reg <= scl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scl_ready && scl_valid) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
